### design/gwc_pkg.sv
// Shared constants and the modulo-2017 reduction for the walk counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gwc_pkg;
  localparam int MATRIX_DIM_DEF = 32;
  localparam int VAL_W          = 11;
  localparam int PROD_W         = 2 * VAL_W;
  localparam int ACC_MAX_W      = 28;      // holds 64 products of 2016*2016
  localparam int WALK_MOD       = 2017;
  localparam int NODE_W         = 5;
  localparam int STEPS_W        = 32;
  localparam int S_TDATA_W      = 48;
  localparam int M_TDATA_W      = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 1'b1;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // 2048 = 31 mod 2017, so fold the bits above bit 10 back in a few times
  function automatic logic [VAL_W-1:0] red_mod(input logic [ACC_MAX_W-1:0] x);
    logic [22:0] t1;
    logic [16:0] t2;
    logic [11:0] t3;
    logic [11:0] t4;
    t1 = (23'(x[ACC_MAX_W-1:11]) << 5) - 23'(x[ACC_MAX_W-1:11]) + 23'(x[10:0]);
    t2 = (17'(t1[22:11]) << 5) - 17'(t1[22:11]) + 17'(t1[10:0]);
    t3 = (12'(t2[16:11]) << 5) - 12'(t2[16:11]) + 12'(t2[10:0]);
    t4 = (t3[11] ? 12'd31 : 12'd0) + 12'(t3[10:0]);
    if (t4 >= 12'(WALK_MOD)) t4 = t4 - 12'(WALK_MOD);
    return t4[VAL_W-1:0];
  endfunction
endpackage
`default_nettype wire

### design/gwc_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gwc_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/gwc_mac_row.sv
// Row of multiply-accumulate lanes: one product row of a matrix multiply.
// Depends on gwc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gwc_mac_row #(
  parameter int MATRIX_DIM = gwc_pkg::MATRIX_DIM_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         clr,
  input  logic                                         en,
  input  logic [gwc_pkg::VAL_W-1:0]                    x,
  input  logic [MATRIX_DIM-1:0][gwc_pkg::VAL_W-1:0]    y,
  output logic [MATRIX_DIM-1:0][gwc_pkg::VAL_W-1:0]    res
);
  import gwc_pkg::*;
  localparam int ACC_W = PROD_W + $clog2(MATRIX_DIM);

  logic [MATRIX_DIM-1:0][PROD_W-1:0] prod;
  logic [MATRIX_DIM-1:0][ACC_W-1:0]  acc;
  logic                              pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= en;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MATRIX_DIM; j++) begin
      if (en) prod[j] <= PROD_W'(x) * PROD_W'(y[j]);
      if (clr) acc[j] <= '0;
      else if (pv) acc[j] <= acc[j] + ACC_W'(prod[j]);
    end
  end

  always_comb begin
    for (int j = 0; j < MATRIX_DIM; j++) res[j] = red_mod(ACC_MAX_W'(acc[j]));
  end
endmodule
`default_nettype wire

### design/graph_walk_count_matrix_power.sv
// Walk counter: edges in a row-wide bit store, matrix power by square-and-multiply.
// Edge request: read and write back the row of each end node. Run request: build
// d rows (d = node_count+1), square-and-multiply products row by row, then the row
// sum; the MAC row and matrix RAM read ports set the pace. One request at a time.
// Reset clears control state and the adjacency row valid bits at once; no clearing pass.
// Depends on gwc_pkg, gwc_ram, gwc_mac_row.
`timescale 1ns / 1ps
`default_nettype none
module graph_walk_count_matrix_power #(
  parameter int MATRIX_DIM = gwc_pkg::MATRIX_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [4:0] node_a, [9:5] node_b, [41:10] steps, rest zero
  input  logic [gwc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [0] command
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [10:0] walk_count, rest zero
  output logic [gwc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [gwc_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [gwc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import gwc_pkg::*;
  localparam int IW = $clog2(MATRIX_DIM);
  localparam int CW = IW + 1;
  localparam int RW = MATRIX_DIM * VAL_W;

  typedef logic [MATRIX_DIM-1:0][VAL_W-1:0] row_t;

  typedef enum logic [19:0] {
    ST_IDLE  = 20'h00001, ST_E_RDA = 20'h00002, ST_E_WRA = 20'h00004,
    ST_E_RDB = 20'h00008, ST_E_WRB = 20'h00010, ST_B_RD  = 20'h00020,
    ST_B_WR  = 20'h00040, ST_CHK   = 20'h00080, ST_SHF   = 20'h00100,
    ST_M_XRD = 20'h00200, ST_M_XLAT= 20'h00400, ST_M_RUN = 20'h00800,
    ST_M_DRN = 20'h01000, ST_M_WR  = 20'h02000, ST_C_RD  = 20'h04000,
    ST_C_WR  = 20'h08000, ST_S_RD  = 20'h10000, ST_S_LAT = 20'h20000,
    ST_S_ACC = 20'h40000, ST_DONE  = 20'h80000
  } state_t;

  state_t state;
  logic [NODE_W-1:0]     node_count, start_node;
  logic [CW-1:0]         dim_r, start_r, i, k, k_d, j;
  logic [1:0]            drn;
  logic [STEPS_W-1:0]    steps_r;
  logic                  op_sq, rd_v;
  logic [IW-1:0]         ea, eb;
  logic [MATRIX_DIM-1:0] adj_valid;
  row_t                  x_row, mac_res, bld_base, bld_pow;
  logic [VAL_W-1:0]      sum, sum_next;
  logic                  out_valid;
  logic [VAL_W-1:0]      out_count;

  logic                  adj_re, adj_we, base_re, base_we, pow_re, pow_we, scr_re, scr_we;
  logic [IW-1:0]         adj_raddr, adj_waddr, adj_sel, base_raddr, pow_raddr;
  logic [MATRIX_DIM-1:0] adj_rdata, adj_row, adj_wdata, set_mask;
  logic [RW-1:0]         base_rdata, pow_rdata, scr_rdata, base_wdata, pow_wdata;
  logic [CW-1:0]         dim_sel;
  logic                  edge_ok, in_req;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_TDATA_W'(out_count);

  assign dim_sel = ((int'(node_count) > MATRIX_DIM - 1) ? CW'(MATRIX_DIM - 1)
                                                         : CW'(node_count)) + CW'(1);
  assign edge_ok = (int'(s_axis_tdata[4:0]) < MATRIX_DIM) &&
                   (int'(s_axis_tdata[9:5]) < MATRIX_DIM);

  // row being written back reads as empty until first written
  always_comb begin
    case (state)
      ST_E_WRA: adj_sel = ea;
      ST_E_WRB: adj_sel = eb;
      default:  adj_sel = i[IW-1:0];
    endcase
    adj_row = adj_valid[adj_sel] ? adj_rdata : '0;
    for (int b = 0; b < MATRIX_DIM; b++) begin
      set_mask[b] = (state == ST_E_WRA) ? (b == int'(eb)) : (b == int'(ea));
    end
    adj_wdata = adj_row | set_mask;
  end

  always_comb begin
    for (int c = 0; c < MATRIX_DIM; c++) begin
      bld_base[c] = (c < int'(dim_r) && (adj_row[c] || c == int'(i) || c == 0)) ?
                    VAL_W'(1) : VAL_W'(0);
      bld_pow[c]  = (c == int'(i)) ? VAL_W'(1) : VAL_W'(0);
    end
  end

  always_comb begin
    adj_re = 1'b0; adj_we = 1'b0; adj_raddr = ea; adj_waddr = adj_sel;
    base_re = 1'b0; base_we = 1'b0; base_raddr = i[IW-1:0];
    pow_re = 1'b0; pow_we = 1'b0; pow_raddr = i[IW-1:0];
    scr_re = 1'b0; scr_we = 1'b0;
    base_wdata = RW'(bld_base);
    pow_wdata  = RW'(bld_pow);
    case (state)
      ST_E_RDA: adj_re = 1'b1;
      ST_E_WRA: adj_we = 1'b1;
      ST_E_RDB: begin
        adj_re = 1'b1; adj_raddr = eb;
      end
      ST_E_WRB: adj_we = 1'b1;
      ST_B_RD: begin
        adj_re = 1'b1; adj_raddr = i[IW-1:0];
      end
      ST_B_WR: begin
        base_we = 1'b1; pow_we = 1'b1;
      end
      ST_M_XRD: begin
        if (op_sq) base_re = 1'b1;
        else pow_re = 1'b1;
      end
      ST_M_RUN: begin
        base_re = 1'b1; base_raddr = k[IW-1:0];
      end
      ST_M_WR: scr_we = 1'b1;
      ST_C_RD: scr_re = 1'b1;
      ST_C_WR: begin
        base_wdata = scr_rdata; pow_wdata = scr_rdata;
        if (op_sq) base_we = 1'b1;
        else pow_we = 1'b1;
      end
      ST_S_RD: begin
        pow_re = 1'b1; pow_raddr = start_r[IW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    logic [VAL_W:0] t;
    t = (VAL_W+1)'(sum) + (VAL_W+1)'(x_row[j[IW-1:0]]);
    if (t >= (VAL_W+1)'(WALK_MOD)) t = t - (VAL_W+1)'(WALK_MOD);
    sum_next = t[VAL_W-1:0];
  end

  gwc_ram #(.DEPTH(MATRIX_DIM), .WIDTH(MATRIX_DIM)) u_adj (
    .clk, .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata)
  );
  gwc_ram #(.DEPTH(MATRIX_DIM), .WIDTH(RW)) u_base (
    .clk, .we(base_we), .waddr(i[IW-1:0]), .wdata(base_wdata),
    .re(base_re), .raddr(base_raddr), .rdata(base_rdata)
  );
  gwc_ram #(.DEPTH(MATRIX_DIM), .WIDTH(RW)) u_pow (
    .clk, .we(pow_we), .waddr(i[IW-1:0]), .wdata(pow_wdata),
    .re(pow_re), .raddr(pow_raddr), .rdata(pow_rdata)
  );
  gwc_ram #(.DEPTH(MATRIX_DIM), .WIDTH(RW)) u_scr (
    .clk, .we(scr_we), .waddr(i[IW-1:0]), .wdata(RW'(mac_res)),
    .re(scr_re), .raddr(i[IW-1:0]), .rdata(scr_rdata)
  );

  gwc_mac_row #(.MATRIX_DIM(MATRIX_DIM)) u_mac (
    .clk, .rst, .clr(state == ST_M_XLAT), .en(rd_v),
    .x(x_row[k_d[IW-1:0]]), .y(row_t'(base_rdata)), .res(mac_res)
  );

  always_ff @(posedge clk) begin
    rd_v <= (state == ST_M_RUN);
    k_d  <= k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      adj_valid  <= '0;
      node_count <= NODE_W'(1);
      start_node <= NODE_W'(1);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_NODE_COUNT: node_count <= cfg_data;
          CFG_START_NODE: start_node <= cfg_data;
          default: ;
        endcase
      end
      // the done state loads the result register itself
      if (m_axis_tready && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_req) begin
            ea <= IW'(s_axis_tdata[4:0]);
            eb <= IW'(s_axis_tdata[9:5]);
            dim_r   <= dim_sel;
            start_r <= (int'(start_node) < MATRIX_DIM) ? CW'(start_node) : CW'(MATRIX_DIM);
            steps_r <= s_axis_tdata[41:10];
            i       <= '0;
            if (s_axis_tuser == CMD_RUN) state <= ST_B_RD;
            else if (edge_ok) state <= ST_E_RDA;
          end
        end
        ST_E_RDA: state <= ST_E_WRA;
        ST_E_WRA: begin
          adj_valid[ea] <= 1'b1;
          state <= ST_E_RDB;
        end
        ST_E_RDB: state <= ST_E_WRB;
        ST_E_WRB: begin
          adj_valid[eb] <= 1'b1;
          state <= ST_IDLE;
        end
        ST_B_RD: state <= ST_B_WR;
        ST_B_WR: begin
          if (i + CW'(1) == dim_r) begin
            i <= '0;
            state <= ST_CHK;
          end else begin
            i <= i + CW'(1);
            state <= ST_B_RD;
          end
        end
        ST_CHK: begin
          if (steps_r == '0) begin
            sum <= '0;
            state <= (start_r < dim_r) ? ST_S_RD : ST_DONE;
          end else if (steps_r[0]) begin
            op_sq <= 1'b0;
            state <= ST_M_XRD;
          end else begin
            state <= ST_SHF;
          end
        end
        ST_SHF: begin
          steps_r <= steps_r >> 1;
          if (steps_r[STEPS_W-1:1] != '0) begin
            op_sq <= 1'b1;
            state <= ST_M_XRD;
          end else begin
            state <= ST_CHK;
          end
        end
        ST_M_XRD: state <= ST_M_XLAT;
        ST_M_XLAT: begin
          x_row <= op_sq ? row_t'(base_rdata) : row_t'(pow_rdata);
          k <= '0;
          state <= ST_M_RUN;
        end
        ST_M_RUN: begin
          k <= k + CW'(1);
          if (k + CW'(1) == dim_r) begin
            drn <= '0;
            state <= ST_M_DRN;
          end
        end
        ST_M_DRN: begin
          drn <= drn + 2'd1;
          if (drn == 2'd2) state <= ST_M_WR;
        end
        ST_M_WR: begin
          if (i + CW'(1) == dim_r) begin
            i <= '0;
            state <= ST_C_RD;
          end else begin
            i <= i + CW'(1);
            state <= ST_M_XRD;
          end
        end
        ST_C_RD: state <= ST_C_WR;
        ST_C_WR: begin
          if (i + CW'(1) == dim_r) begin
            i <= '0;
            state <= op_sq ? ST_CHK : ST_SHF;
          end else begin
            i <= i + CW'(1);
            state <= ST_C_RD;
          end
        end
        ST_S_RD: state <= ST_S_LAT;
        ST_S_LAT: begin
          x_row <= row_t'(pow_rdata);
          j <= '0;
          state <= ST_S_ACC;
        end
        ST_S_ACC: begin
          sum <= sum_next;
          j <= j + CW'(1);
          if (j + CW'(1) == dim_r) state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_count <= sum;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/gwc_checker.sv
// Port-level checks for the walk counter, bound to the top level.
// Depends on gwc_pkg and graph_walk_count_matrix_power.
`timescale 1ns / 1ps
`default_nettype none
module gwc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [gwc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [gwc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import gwc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata < M_TDATA_W'(WALK_MOD)))
    else $error("walk count out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_RUN |=> !s_axis_tready)
    else $error("run request did not occupy the block");
endmodule

bind graph_walk_count_matrix_power gwc_checker u_gwc_checker (.*);
`default_nettype wire

### tb/graph_walk_count_matrix_power_test.sv
// Testbench for graph_walk_count_matrix_power: edge and run requests, walk counts checked
// against a matrix-power predictor kept in the bench. Depends on gwc_pkg and the block.
`timescale 1ns / 1ps
module graph_walk_count_matrix_power_test;
  import gwc_pkg::*;

  localparam int DIM = 32;
  localparam longint CYCLE_LIMIT = 20_000_000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  graph_walk_count_matrix_power u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // bench copy of the block state
  bit edge_bits [DIM][DIM];
  logic [NODE_W-1:0] top_node;
  logic [NODE_W-1:0] row_sel;
  int unsigned base_m [DIM][DIM];
  int unsigned pow_m [DIM][DIM];
  int unsigned prod_m [DIM][DIM];

  logic [VAL_W-1:0] pending_counts[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // dest = (into_power ? pow : base) * base, entries mod 2017
  function automatic void mat_mult(bit into_power, int dim);
    int unsigned acc;
    for (int i = 0; i < dim; i++)
      for (int j = 0; j < dim; j++) begin
        acc = 0;
        for (int k = 0; k < dim; k++)
          acc = (acc + (into_power ? pow_m[i][k] : base_m[i][k]) * base_m[k][j]) % WALK_MOD;
        prod_m[i][j] = acc;
      end
    for (int i = 0; i < dim; i++)
      for (int j = 0; j < dim; j++)
        if (into_power) pow_m[i][j] = prod_m[i][j];
        else base_m[i][j] = prod_m[i][j];
  endfunction

  function automatic logic [VAL_W-1:0] walk_count(logic [STEPS_W-1:0] steps);
    int dim;
    int unsigned sum;
    dim = int'(top_node) + 1;
    for (int i = 0; i < dim; i++)
      for (int j = 0; j < dim; j++) begin
        base_m[i][j] = (i == j || j == 0 || edge_bits[i][j]) ? 1 : 0;
        pow_m[i][j] = (i == j) ? 1 : 0;
      end
    while (steps != 0) begin
      if (steps[0]) mat_mult(1'b1, dim);
      steps = steps >> 1;
      if (steps != 0) mat_mult(1'b0, dim);
    end
    sum = 0;
    if (int'(row_sel) < dim)
      for (int j = 0; j < dim; j++) sum = (sum + pow_m[row_sel][j]) % WALK_MOD;
    return VAL_W'(sum);
  endfunction

  task automatic send_request(logic cmd, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                              logic [STEPS_W-1:0] steps);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {6'd0, steps, b, a};
    do @(posedge clk); while (!s_axis_tready);
    if (cmd == CMD_EDGE) begin
      edge_bits[a][b] = 1'b1;
      edge_bits[b][a] = 1'b1;
    end else begin
      pending_counts.push_back(walk_count(steps));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic set_config(logic [NODE_W-1:0] n, logic [NODE_W-1:0] s);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_NODE_COUNT;
    cfg_data <= n;
    @(posedge clk);
    cfg_addr <= CFG_START_NODE;
    cfg_data <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    top_node = n;
    row_sel = s;
  endtask

  task automatic test_reset_defaults();
    send_request(CMD_RUN, 5'd0, 5'd0, 32'd0);   // zero steps gives 1
    send_request(CMD_RUN, 5'd0, 5'd0, 32'd1);
    send_request(CMD_RUN, 5'd31, 5'd31, 32'd5);
    drain();
  endtask

  task automatic test_edge_cases();
    set_config(5'd0, 5'd0);                      // 1x1 matrix
    send_request(CMD_RUN, 5'd0, 5'd0, 32'hFFFF_FFFF);
    drain();
    set_config(5'd2, 5'd5);                      // start row outside the matrix
    send_request(CMD_EDGE, 5'd1, 5'd2, 32'd0);
    send_request(CMD_RUN, 5'd0, 5'd0, 32'd3);
    drain();
    set_config(5'd3, 5'd0);
    send_request(CMD_RUN, 5'd0, 5'd0, 32'd7);    // node 0 still absorbing
    send_request(CMD_EDGE, 5'd0, 5'd3, 32'd0);   // edge into node 0
    send_request(CMD_EDGE, 5'd2, 5'd2, 32'd0);   // self edge
    send_request(CMD_EDGE, 5'd3, 5'd0, 32'd0);   // repeat
    send_request(CMD_EDGE, 5'd3, 5'd20, 32'd0);  // beyond n, stored but unused
    send_request(CMD_RUN, 5'd0, 5'd0, 32'd7);
    send_request(CMD_RUN, 5'd0, 5'd0, 32'h8000_0001);
    drain();
    set_config(5'd31, 5'd31);                    // full size
    send_request(CMD_EDGE, 5'd31, 5'd30, 32'd0);
    send_request(CMD_RUN, 5'd0, 5'd0, 32'd2);
    send_request(CMD_RUN, 5'd0, 5'd0, 32'hFFFF_FFFF);
    drain();
    set_config(5'd20, 5'd3);
    send_request(CMD_RUN, 5'd0, 5'd0, 32'hAAAA_5555);
    drain();
  endtask

  task automatic test_random_phase(int idle, int stall, int count);
    logic [STEPS_W-1:0] steps;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    // small matrices keep each run short; steps take the full 32-bit range
    set_config(NODE_W'($urandom_range(7, 1)), NODE_W'($urandom_range(9)));
    for (int i = 0; i < count; i++) begin
      steps = $urandom;
      if ($urandom_range(3) == 0) steps = steps >> $urandom_range(31);
      if ($urandom_range(99) < 55)
        send_request(CMD_EDGE, NODE_W'($urandom), NODE_W'($urandom), $urandom);
      else
        send_request(CMD_RUN, NODE_W'($urandom), NODE_W'($urandom), steps);
    end
    drain();
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        $error("walk_count: unexpected result %0d", m_axis_tdata[VAL_W-1:0]);
        errors++;
      end else begin
        if (m_axis_tdata[VAL_W-1:0] !== pending_counts[0]) begin
          $error("walk_count: expected %0d, got %0d", pending_counts[0],
                 m_axis_tdata[VAL_W-1:0]);
          errors++;
        end
        void'(pending_counts.pop_front());
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    top_node = 5'd1;
    row_sel = 5'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_edge_cases();
    test_random_phase(0, 0, 25);
    test_random_phase(72, 0, 25);
    test_random_phase(0, 72, 25);
    test_random_phase(38, 38, 25);
    if (errors == 0 && pending_counts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
